>>> rtl/assert_macros.svh
// assertion macros for the histogram block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b on the same clock
`define ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// property a implies b on the next clock
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

>>> rtl/hpw_pkg.sv
// types and constants shared by the histogram controller and datapath
package hpw_pkg;
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_FILL  = 2'd1;
  localparam logic [1:0] CMD_PEAK  = 2'd2;
  localparam logic [1:0] CMD_WIDTH = 2'd3;

  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_BIN_WIDTH  = 2'd2;
  localparam logic [1:0] REG_BINS_USED  = 2'd3;

  localparam logic [16:0] LEVEL_ONE = 17'd65536;
  localparam int DIV_BITS = 34;

  typedef struct packed {
    logic load;
    logic div_start;
    logic fill_read;
    logic fill_write;
    logic clr_start;
    logic clr_step;
    logic scan_start;
    logic scan_step;
    logic thr_calc;
    logic count_start;
    logic count_step;
    logic finish_fill;
    logic finish_peak;
    logic finish_width;
    logic finish_clear;
    logic finish_reject;
    logic finish_level;
  } hpw_cmd_t;

  typedef struct packed {
    logic div_done;
    logic fill_ok;
    logic scan_last;
    logic clr_last;
    logic level_bad;
  } hpw_stat_t;
endpackage

>>> rtl/hpw_ctrl.sv
// controller state machine for the histogram block
module hpw_ctrl
  import hpw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] command,
  input  hpw_stat_t  stat,
  output hpw_cmd_t   cmd,
  output logic       busy
);
  `include "assert_macros.svh"

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_READ   = 4'd2;
  localparam logic [3:0] S_WRITE  = 4'd4;
  localparam logic [3:0] S_CLR    = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_THR    = 4'd7;
  localparam logic [3:0] S_COUNT  = 4'd8;
  localparam logic [3:0] S_PEAKO  = 4'd9;
  localparam logic [3:0] S_WIDTHO = 4'd10;
  localparam logic [3:0] S_SCANW  = 4'd11;
  localparam logic [3:0] S_PRE    = 4'd12;
  localparam logic [3:0] S_CNTW   = 4'd13;

  logic [3:0] state, state_next;
  logic [1:0] op, op_next;
  logic init;

  // reset starts a silent clearing pass over the bin memory
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PRE;
      op <= CMD_CLEAR;
      init <= 1'b1;
    end else begin
      state <= state_next;
      op <= op_next;
      if (state == S_CLR && stat.clr_last) init <= 1'b0;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op_next = op;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          op_next = command;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        unique case (op)
          CMD_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next = S_CLR;
          end
          CMD_FILL: begin
            if (stat.fill_ok) begin
              cmd.div_start = 1'b1;
              state_next = S_DIV;
            end else begin
              cmd.finish_reject = 1'b1;
              state_next = S_IDLE;
            end
          end
          CMD_PEAK: begin
            cmd.scan_start = 1'b1;
            state_next = S_SCANW;
          end
          CMD_WIDTH: begin
            if (stat.level_bad) begin
              cmd.finish_level = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.scan_start = 1'b1;
              state_next = S_SCANW;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (stat.fill_ok) begin
            state_next = S_READ;
          end else begin
            cmd.finish_reject = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_READ: begin
        cmd.fill_read = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.fill_write = 1'b1;
        cmd.finish_fill = 1'b1;
        state_next = S_IDLE;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          cmd.finish_clear = !init;
          state_next = S_IDLE;
        end
      end
      S_SCANW: state_next = S_SCAN;
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = (op == CMD_PEAK) ? S_PEAKO : S_THR;
        end
      end
      S_PEAKO: begin
        cmd.finish_peak = 1'b1;
        state_next = S_IDLE;
      end
      S_THR: begin
        cmd.thr_calc = 1'b1;
        cmd.count_start = 1'b1;
        state_next = S_CNTW;
      end
      S_CNTW: state_next = S_COUNT;
      S_COUNT: begin
        cmd.count_step = 1'b1;
        if (stat.scan_last) state_next = S_WIDTHO;
      end
      S_WIDTHO: begin
        cmd.finish_width = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ASSERT_IMP(a_load_idle, clk, rst, cmd.load, state == S_IDLE)
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMP(a_write_state, clk, rst, cmd.fill_write, op == CMD_FILL)
endmodule

>>> rtl/hpw_div.sv
// restoring divider, one quotient bit per cycle
module hpw_div
  import hpw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0] divisor,
  output logic [DIV_BITS-1:0] quotient,
  output logic                done
);
  logic [DIV_BITS-1:0] rem, quo, dvs;
  logic [5:0] cnt;
  logic running;
  logic [DIV_BITS:0] trial;

  assign trial = {rem, quo[DIV_BITS-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt <= 6'(DIV_BITS);
      end else if (running) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (running) begin
      if (!trial[DIV_BITS]) begin
        rem <= trial[DIV_BITS-1:0];
        quo <= {quo[DIV_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_BITS-2:0], quo[DIV_BITS-1]};
        quo <= {quo[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
endmodule

>>> rtl/hpw_dpath.sv
// datapath: bin memory, divider, scan and result registers
module hpw_dpath
  import hpw_pkg::*;
#(
  parameter int MAX_BINS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  hpw_cmd_t           cmd,
  output hpw_stat_t          stat,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         command,
  input  logic signed [31:0] sample,
  input  logic [16:0]        level_fraction,
  output logic               done,
  output logic               accepted,
  output logic signed [31:0] value,
  output logic [31:0]        peak_count,
  output logic [7:0]         bin_index
);
  localparam int AW = $clog2(MAX_BINS);
  localparam int NW = AW + 1;
  localparam int CW = AW + 34;
  localparam logic signed [CW-1:0] VMAX = CW'(64'sd2147483647);
  localparam logic signed [CW-1:0] VMIN = CW'(-64'sd2147483648);

  logic signed [31:0] range_low, range_high;
  logic [30:0] bin_width;
  logic [8:0] bins_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low <= 32'sd0;
      range_high <= 32'sd16777216;
      bin_width <= 31'd65536;
      bins_in_use <= 9'd256;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        REG_BIN_WIDTH:  bin_width <= cfg_data[30:0];
        REG_BINS_USED:  bins_in_use <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // per transaction operands
  logic signed [31:0] lo, hi, smp;
  logic [30:0] w;
  logic [NW-1:0] n;
  logic [16:0] lf;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo <= (range_low < range_high) ? range_low : range_high;
      hi <= (range_low < range_high) ? range_high : range_low;
      w <= (bin_width == '0) ? 31'd1 : bin_width;
      if (bins_in_use == '0) n <= NW'(1);
      else if ({23'd0, bins_in_use} > 32'(MAX_BINS)) n <= NW'(MAX_BINS);
      else n <= NW'(bins_in_use);
      smp <= sample;
      lf <= level_fraction;
    end
  end

  // fill divider
  logic [DIV_BITS-1:0] quo;
  logic div_done;
  logic [32:0] sdiff;
  logic [33:0] diff2;
  assign sdiff = 33'(signed'({smp[31], smp}) - signed'({lo[31], lo}));
  assign diff2 = {sdiff, 1'b0} + {3'b0, w};

  hpw_div u_div (
    .clk(clk), .rst(rst), .go(cmd.div_start),
    .dividend(diff2), .divisor({2'b0, w, 1'b0}),
    .quotient(quo), .done(div_done)
  );

  logic in_range;
  assign in_range = (smp > lo) && (smp < hi) && !((smp > -32'sd7) && (smp < 32'sd7));
  logic idx_ok;
  assign idx_ok = (quo < DIV_BITS'(n));

  // bin memory and clear sweep
  logic [31:0] mem [MAX_BINS];
  logic [AW-1:0] raddr, waddr, ptr;
  logic [31:0] rdata, wdata;
  logic we;
  logic [AW-1:0] fidx;
  logic [NW-1:0] pos;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_read) fidx <= quo[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_start || cmd.scan_start || cmd.count_start) ptr <= '0;
    else if (cmd.clr_step || cmd.scan_step || cmd.count_step) ptr <= ptr + AW'(1);
  end

  // during a scan the read runs one bin ahead of the bin being compared
  always_comb begin
    raddr = ptr;
    if (cmd.scan_step || cmd.count_step) raddr = ptr + AW'(1);
    if (cmd.fill_read) raddr = quo[AW-1:0];
    we = 1'b0;
    waddr = ptr;
    wdata = '0;
    if (cmd.clr_step) we = 1'b1;
    if (cmd.fill_write) begin
      we = 1'b1;
      waddr = fidx;
      wdata = (rdata == 32'hFFFF_FFFF) ? rdata : rdata + 32'd1;
    end
  end

  // scan: pos is the bin whose data is in rdata
  always_ff @(posedge clk) begin
    if (cmd.scan_start || cmd.count_start) pos <= '0;
    else if (cmd.scan_step || cmd.count_step) pos <= pos + 1'b1;
  end

  logic [31:0] best;
  logic [AW-1:0] bi;
  logic [32:0] thr;
  logic [NW-1:0] cnt;
  logic [48:0] prod;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best <= '0;
      bi <= '0;
    end else if (cmd.scan_step && rdata > best) begin
      best <= rdata;
      bi <= pos[AW-1:0];
    end
    if (cmd.thr_calc) prod <= {17'd0, best} * {32'd0, lf};
    if (cmd.count_start) cnt <= '0;
    else if (cmd.count_step && {1'b0, rdata} >= thr) cnt <= cnt + 1'b1;
  end
  assign thr = 33'((prod + 49'd32768) >> 16);

  // result computation
  logic [CW-1:0] cprod;
  logic signed [CW-1:0] centre;
  logic [CW-1:0] wprod;
  logic [NW-1:0] cnt1;
  assign cprod = CW'({bi, 1'b1}) * CW'(w) + CW'(1);
  assign centre = CW'(lo) + signed'(cprod >> 1);
  assign cnt1 = (cnt == '0) ? NW'(1) : cnt;
  assign wprod = CW'(cnt1) * CW'(w);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.finish_fill | cmd.finish_peak | cmd.finish_width |
                 cmd.finish_clear | cmd.finish_reject | cmd.finish_level;
    accepted <= 1'b0;
    value <= '0;
    peak_count <= '0;
    bin_index <= '0;
    if (cmd.finish_fill) begin
      accepted <= 1'b1;
      bin_index <= 8'(fidx);
    end
    if (cmd.finish_clear) accepted <= 1'b1;
    if (cmd.finish_level) value <= {1'b0, w};
    if (cmd.finish_peak) begin
      accepted <= 1'b1;
      if (centre > VMAX) value <= 32'h7FFF_FFFF;
      else if (centre < VMIN) value <= 32'h8000_0000;
      else value <= centre[31:0];
      peak_count <= best;
      bin_index <= 8'(bi);
    end
    if (cmd.finish_width) begin
      accepted <= 1'b1;
      value <= (wprod > CW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : wprod[31:0];
      peak_count <= best;
      bin_index <= 8'(bi);
    end
  end

  always_comb begin
    stat.div_done = div_done;
    stat.fill_ok = (command == CMD_FILL) ? in_range : in_range;
    if (div_done) stat.fill_ok = idx_ok;
    stat.scan_last = (pos == n - 1'b1) && (cmd.scan_step || cmd.count_step);
    stat.clr_last = (ptr == AW'(MAX_BINS - 1));
    stat.level_bad = (lf > LEVEL_ONE);
  end
endmodule

>>> rtl/histogram_peak_and_width.sv
// top level of the histogram peak and width block
// A transaction is taken when start is high and busy low; busy stays high until the
// single result strobe (done) and the receiver cannot stall it. A fill runs the
// 34-step restoring divider and then the bin read-modify-write; a sample at or outside
// the limits or in the dead zone is rejected without running the divider. Clear writes
// all MAX_BINS memory rows, one row a cycle. A peak query scans the n active bins and
// a width query scans them twice, one memory read per cycle; a width query with a level
// above one is rejected without a scan. After reset busy stays high while the bins clear.
module histogram_peak_and_width
  import hpw_pkg::*;
#(
  parameter int MAX_BINS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         command,
  input  logic signed [31:0] sample,
  input  logic [16:0]        level_fraction,
  output logic               done,
  output logic               accepted,
  output logic signed [31:0] value,
  output logic [31:0]        peak_count,
  output logic [7:0]         bin_index
);
  hpw_cmd_t cmd;
  hpw_stat_t stat;

  hpw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(command),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  hpw_dpath #(.MAX_BINS(MAX_BINS)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .command(command), .sample(sample), .level_fraction(level_fraction),
    .done(done), .accepted(accepted), .value(value),
    .peak_count(peak_count), .bin_index(bin_index)
  );
endmodule
